>>> design/bfiq_pkg.sv
// Package with shared types and constants for the Bloom filter core.
package bfiq_pkg;

  localparam int unsigned StoreBits  = 65536;
  localparam int unsigned AddrW      = $clog2(StoreBits);
  localparam int unsigned MaxHashes  = 6;
  localparam int unsigned HashIdxW   = 3;
  localparam int unsigned HashW      = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned BitCountW  = 17;
  localparam int unsigned SeedW      = 20;
  localparam int unsigned CountW     = 32;

  localparam logic [CfgIdxW-1:0] RegBitCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHashCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeedZero  = 3'd2;

  // Payload of one input beat: one byte of an element string.
  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic       last_byte;
  } bfiq_in_t;

  // Payload of one result beat.
  typedef struct packed {
    logic              maybe_present;
    logic              was_query;
    logic [CountW-1:0] added_count;
  } bfiq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             clr_en;     // write zero at clr address
    logic             byte_en;    // update running hashes with in byte
    logic             load_seeds; // first byte of a string
    logic             mod_start;  // start reducing hash index sel
    logic [HashIdxW-1:0] sel;
    logic             rd_en;      // read store at reduced position
    logic             wr_en;      // set store bit at reduced position
    logic             chk_en;     // fold read bit into all-set flag
    logic             res_init;   // clear all-set flag
    logic             cnt_inc;    // count an add
  } bfiq_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
  } bfiq_sts_t;

endpackage

>>> design/bfiq_stream_if.sv
// Valid/ready stream interface carrying a payload of a given type.
interface bfiq_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/bfiq_datapath.sv
// Datapath: running hashes, restoring modulo unit, bit store and counter.
module bfiq_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bfiq_pkg::bfiq_cmd_t       cmd_i,
  output bfiq_pkg::bfiq_sts_t       sts_o,
  input  logic [7:0]                byte_i,
  input  logic [bfiq_pkg::SeedW-1:0] seed_i [bfiq_pkg::MaxHashes],
  input  logic [bfiq_pkg::BitCountW-1:0] mod_i,
  output logic                      all_set_o,
  output logic [bfiq_pkg::CountW-1:0] count_o
);
  localparam int unsigned HW = bfiq_pkg::HashW;
  localparam int unsigned MW = bfiq_pkg::BitCountW;
  localparam int unsigned AW = bfiq_pkg::AddrW;

  logic [HW-1:0] hash_q [bfiq_pkg::MaxHashes];
  logic [HW-1:0] ext;
  assign ext = {{(HW-8){byte_i[7]}}, byte_i};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < bfiq_pkg::MaxHashes; i++) begin
      if (cmd_i.byte_en) begin
        if (cmd_i.load_seeds) begin
          hash_q[i] <= ({{(HW-bfiq_pkg::SeedW){1'b0}}, seed_i[i]} << 5)
                       - {{(HW-bfiq_pkg::SeedW){1'b0}}, seed_i[i]} + ext;
        end else begin
          hash_q[i] <= (hash_q[i] << 5) - hash_q[i] + ext;
        end
      end
    end
  end

  // Restoring division, one quotient bit a cycle, remainder kept.
  logic [HW-1:0] dvd_q, dvd_d;
  logic [MW:0]   rem_q, rem_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [MW:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[MW-1:0], dvd_q[HW-1]};
    if (cmd_i.mod_start) begin
      dvd_d  = hash_q[cmd_i.sel];
      rem_d  = '0;
      cnt_d  = 7'(HW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = (trial >= {1'b0, mod_i}) ? trial - {1'b0, mod_i} : trial;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign sts_o.mod_done = done_q;

  // Clearing sweep address.
  logic [AW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
  end
  assign sts_o.clr_last = (clr_q == {AW{1'b1}});

  logic mem_q [bfiq_pkg::StoreBits];
  logic rd_q;
  logic [AW-1:0] pos;
  assign pos = rem_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) mem_q[clr_q] <= 1'b0;
    else if (cmd_i.wr_en) mem_q[pos] <= 1'b1;
    if (cmd_i.rd_en) rd_q <= mem_q[pos];
  end

  logic all_q;
  logic [bfiq_pkg::CountW-1:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q   <= 1'b1;
      count_q <= '0;
    end else begin
      if (cmd_i.res_init) all_q <= 1'b1;
      else if (cmd_i.chk_en) all_q <= all_q & rd_q;
      if (cmd_i.cnt_inc && count_q != {bfiq_pkg::CountW{1'b1}})
        count_q <= count_q + 32'd1;
    end
  end
  assign all_set_o = all_q;
  assign count_o   = count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_start |=> busy_q)
    else $error("modulo unit did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("modulo done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < {1'b0, mod_i}))
    else $error("remainder not below modulus");
endmodule

>>> design/bfiq_ctrl.sv
// Controller state machine sequencing clear, byte and final reduction steps.
module bfiq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  logic                in_func_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_query_o,
  input  logic [2:0]          k_i,
  output bfiq_pkg::bfiq_cmd_t cmd_o,
  input  bfiq_pkg::bfiq_sts_t sts_i
);
  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StMod   = 7'b0000100,
    StMem   = 7'b0001000,
    StChk   = 7'b0010000,
    StOut   = 7'b0100000,
    StLoad  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   in_str_q, in_str_d;
  logic   query_q, query_d;
  logic [bfiq_pkg::HashIdxW-1:0] sel_q, sel_d;
  logic   take;

  assign in_ready_o  = (state_q == StIdle);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_query_o = query_q;

  always_comb begin
    state_d  = state_q;
    in_str_d = in_str_q;
    query_d  = query_q;
    sel_d    = sel_q;
    cmd_o    = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (take) begin
          cmd_o.byte_en    = 1'b1;
          cmd_o.load_seeds = !in_str_q;
          in_str_d = !in_last_i;
          if (in_last_i) begin
            query_d = in_func_i;
            sel_d   = '0;
            cmd_o.res_init = 1'b1;
            state_d = StLoad;
          end
        end
      end
      // The hashes settle with the final byte; reduction starts in the following cycle.
      StLoad: state_d = StMod;
      StMod: begin
        // Start is issued on entry; wait for the remainder.
        if (sts_i.mod_done) begin
          cmd_o.rd_en = query_q;
          cmd_o.wr_en = !query_q;
          state_d = StMem;
        end
      end
      StMem: begin
        cmd_o.chk_en = query_q;
        if (sel_q == k_i - 3'd1) begin
          cmd_o.cnt_inc = !query_q;
          state_d = StChk;
        end else begin
          sel_d = sel_q + 3'd1;
          state_d = StMod;
        end
      end
      StChk: state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    // Kick the modulo unit whenever we enter the reduction state.
    if (state_d == StMod && state_q != StMod) begin
      cmd_o.mod_start = 1'b1;
      cmd_o.sel = sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      in_str_q <= 1'b0;
      query_q  <= 1'b0;
      sel_q    <= '0;
    end else begin
      state_q  <= state_d;
      in_str_q <= in_str_d;
      query_q  <= query_d;
      sel_q    <= sel_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_ready_i) |=> state_q == StOut)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !query_q)
    else $error("query wrote the store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMem) |-> (sel_q < k_i))
    else $error("hash index out of range");
endmodule

>>> design/bloom_filter_insert_query_core.sv
// Top level of the Bloom filter insert/query core.
// After reset the core clears its 65536-bit store, one bit a cycle, before
// taking the first byte beat. A non-final byte only updates the running
// hashes. The final byte of a string runs k reductions (k the hash
// count) through one shared bit-serial modulo unit; each ends with the
// store access and, for a query, is followed by a step that folds in the
// read bit. A load step comes before the reductions and a check step after
// them, before the result beat is offered. The next byte is taken no
// earlier than the cycle after the result beat is accepted.
module bloom_filter_insert_query_core (
  input  logic clk_i,
  input  logic rst_ni,
  bfiq_stream_if.sink   in_if,
  bfiq_stream_if.source out_if,
  input  logic                         cfg_we_i,
  input  logic [bfiq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bfiq_pkg::CfgDataW-1:0] cfg_data_i
);
  logic [bfiq_pkg::BitCountW-1:0] bit_count_q;
  logic [2:0]                     hash_count_q;
  logic [bfiq_pkg::SeedW-1:0]     seed_q [bfiq_pkg::MaxHashes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q  <= 17'd65536;
      hash_count_q <= 3'd4;
      for (int i = 0; i < bfiq_pkg::MaxHashes; i++) seed_q[i] <= 20'(i + 1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfiq_pkg::RegBitCount:  bit_count_q  <= cfg_data_i[bfiq_pkg::BitCountW-1:0];
        bfiq_pkg::RegHashCount: hash_count_q <= cfg_data_i[2:0];
        default: seed_q[cfg_idx_i - bfiq_pkg::RegSeedZero] <= cfg_data_i;
      endcase
    end
  end

  logic [bfiq_pkg::BitCountW-1:0] mod;
  logic [2:0] k;
  always_comb begin
    mod = bit_count_q;
    if (mod == '0) mod = 17'd1;
    if (mod > 17'(bfiq_pkg::StoreBits)) mod = 17'(bfiq_pkg::StoreBits);
    k = hash_count_q;
    if (k == 3'd0) k = 3'd1;
    if (k > 3'(bfiq_pkg::MaxHashes)) k = 3'(bfiq_pkg::MaxHashes);
  end

  bfiq_pkg::bfiq_cmd_t cmd;
  bfiq_pkg::bfiq_sts_t sts;
  logic all_set, query;
  logic [bfiq_pkg::CountW-1:0] count;

  bfiq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.data.last_byte),
    .in_func_i  (in_if.data.func),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_query_o(query),
    .k_i        (k),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bfiq_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i    (cmd),
    .sts_o    (sts),
    .byte_i   (in_if.data.char_byte),
    .seed_i   (seed_q),
    .mod_i    (mod),
    .all_set_o(all_set),
    .count_o  (count)
  );

  assign out_if.data.maybe_present = query ? all_set : 1'b1;
  assign out_if.data.was_query     = query;
  assign out_if.data.added_count   = count;
endmodule
